[hw/rtl/vtw_pkg.sv]
// Shared constants, types and arithmetic helpers of the vertex-to-window projection.
package vtw_pkg;

   // Coefficient format of the matrix lanes.
   localparam int COEF_WIDTH     = 16;
   localparam int COEF_FRAC_BITS = 8;

   localparam int LANE_W    = 16;
   localparam int REG_W     = 64;
   localparam int NUM_REGS  = 8;
   localparam int CSR_IDX_W = 4;
   localparam int REG_IDX_W = 3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_MV_ROW0   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MV_ROW1   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MV_ROW2   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MV_ROW3   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PJ_ROW0   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PJ_ROW1   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PJ_ROW2   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_VIEWPORT  = 4'd7;

   // Point and window formats.
   localparam int PT_W     = 24;
   localparam int PT_FRAC  = 8;
   localparam int DEPTH_W  = 16;

   // Datapath widths, all derived from the coefficient format.
   localparam int EPROD_W = COEF_WIDTH + PT_W;
   localparam int EACC_W  = EPROD_W + 2;
   localparam int EYE_W   = EACC_W - COEF_FRAC_BITS + 1;
   localparam int CPROD_W = COEF_WIDTH + EYE_W;
   localparam int CACC_W  = CPROD_W + 2;
   localparam int CLIP_W  = CACC_W - COEF_FRAC_BITS + 1;
   localparam int W_W     = EYE_W + 1;
   localparam int CMP_W   = (CLIP_W > W_W + 9) ? CLIP_W : W_W + 9;

   // Divider: 26 quotient bits cover the normalised range up to 512.0 in Q.16.
   localparam int DIV_BITS = 26;
   localparam int DIV_RW   = W_W + 27;
   localparam int NDC_W    = DIV_BITS + 1;
   localparam int NDC_SH   = 9;
   localparam int ONE_SH   = 17;

   localparam logic [DIV_BITS-1:0] NDC_LIMIT = DIV_BITS'(1) << (DIV_BITS - 1);
   localparam logic signed [NDC_W:0] ONE_Q16 = (NDC_W + 1)'(65536);

   localparam logic signed [63:0] SCR_MIN = -64'sd8388608;
   localparam logic signed [63:0] SCR_MAX = 64'sd8388607;
   localparam logic signed [63:0] DEP_MAX = 64'sd65535;

   typedef logic signed [COEF_WIDTH-1:0] coef_type;

   typedef struct packed {
      logic       wzero;
      logic [2:0] neg;
      logic [2:0] lim;
   } side_type;

   // Coefficient of one column: low COEF_WIDTH bits of its lane, two's complement.
   function automatic coef_type coef_of(input logic [REG_W-1:0] r, input int col);
      logic [LANE_W-1:0] lane;
      lane = r[LANE_W*col +: LANE_W];
      return coef_type'(lane[COEF_WIDTH-1:0]);
   endfunction

   // Divide by 2^k, rounding to nearest with ties away from zero.
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int k);
      logic [63:0] m;
      logic [63:0] q;
      m = v[63] ? (64'd0 - 64'(v)) : 64'(v);
      q = (m + (64'd1 << (k - 1))) >> k;
      return v[63] ? signed'(64'd0 - q) : signed'(q);
   endfunction

endpackage

[hw/rtl/vtw_divider.sv]
// Pipelined restoring divider, one quotient bit per register stage.
module vtw_divider (
   input  logic                        clock,
   input  logic                        en,
   input  logic [vtw_pkg::DIV_RW-1:0]  num_in,
   input  logic [vtw_pkg::DIV_RW-1:0]  den_in,
   output logic [vtw_pkg::DIV_BITS-1:0] quo_out
);
   import vtw_pkg::*;

   logic [DIV_RW-1:0]   rem_ff [1:DIV_BITS-1];
   logic [DIV_RW-1:0]   den_ff [1:DIV_BITS-1];
   logic [DIV_BITS-1:0] quo_ff [1:DIV_BITS];

   for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
      logic [DIV_RW-1:0]   rem_cur;
      logic [DIV_RW-1:0]   den_cur;
      logic [DIV_BITS-1:0] quo_cur;
      logic [DIV_RW-1:0]   trial;
      logic                ge;

      if (k == 0) begin : g_first
         assign rem_cur = num_in;
         assign den_cur = den_in;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k];
         assign den_cur = den_ff[k];
         assign quo_cur = quo_ff[k];
      end

      assign trial = den_cur << (DIV_BITS - 1 - k);
      assign ge    = (rem_cur >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[k+1] <= {quo_cur[DIV_BITS-2:0], ge};
         end
      end

      if (k < DIV_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1] <= ge ? (rem_cur - trial) : rem_cur;
               den_ff[k+1] <= den_cur;
            end
         end
      end
   end

   assign quo_out = quo_ff[DIV_BITS];

endmodule

[hw/rtl/vertex_to_window_projection_top.sv]
// Top level of the vertex-to-window projection pipeline.
//
//   Channel   Direction  Ports                                   Transfer when
//   req       in         req_point_x/y/z                         req_valid & req_ready
//   rsp       out        rsp_screen_x/y, rsp_depth, flags        rsp_valid & rsp_ready
//   csr       in         csr_index, csr_data                     csr_valid & csr_ready
//
// One point is taken per clock while rsp does not stall; there are four stages for the two
// matrix products, one set-up stage, 26 divider stages (one quotient bit each) and two
// stages for the viewport mapping, the last being the output register.
// Reset loads identity matrices and a zero viewport and empties the pipeline.
// A stall on rsp freezes every stage at once, so nothing is lost or repeated; req_ready
// stays high whenever the output register is empty or being drained.
module vertex_to_window_projection_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [23:0]                req_point_x,
   input  logic signed [23:0]                req_point_y,
   input  logic signed [23:0]                req_point_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [23:0]                rsp_screen_x,
   output logic signed [23:0]                rsp_screen_y,
   output logic [15:0]                       rsp_depth,
   output logic                              rsp_valid_res,
   output logic                              rsp_clamped,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [vtw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [vtw_pkg::REG_W-1:0]         csr_data
);
   import vtw_pkg::*;

   // The whole pipeline moves as one when the output register can take a result.
   logic en;
   logic out_vld_ff;
   assign en        = !out_vld_ff || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   // Configuration registers.
   logic [REG_W-1:0] regs_ff [NUM_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[REG_MV_ROW0[REG_IDX_W-1:0]]  <= REG_W'(256);
         regs_ff[REG_MV_ROW1[REG_IDX_W-1:0]]  <= REG_W'(256) << 16;
         regs_ff[REG_MV_ROW2[REG_IDX_W-1:0]]  <= REG_W'(256) << 32;
         regs_ff[REG_MV_ROW3[REG_IDX_W-1:0]]  <= REG_W'(256) << 48;
         regs_ff[REG_PJ_ROW0[REG_IDX_W-1:0]]  <= REG_W'(256);
         regs_ff[REG_PJ_ROW1[REG_IDX_W-1:0]]  <= REG_W'(256) << 16;
         regs_ff[REG_PJ_ROW2[REG_IDX_W-1:0]]  <= REG_W'(256) << 32;
         regs_ff[REG_VIEWPORT[REG_IDX_W-1:0]] <= '0;
      end else if (csr_valid && csr_index < CSR_IDX_W'(NUM_REGS)) begin
         // Writes to an index beyond the register list are dropped.
         regs_ff[csr_index[REG_IDX_W-1:0]] <= csr_data;
      end
   end

   // Stage 1: the twelve products of the modelview matrix with the point.
   logic signed [PT_W-1:0]    pt [3];
   logic signed [EPROD_W-1:0] eprod_ff [4][3];
   logic                      s1_vld_ff;

   assign pt[0] = req_point_x;
   assign pt[1] = req_point_y;
   assign pt[2] = req_point_z;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
               eprod_ff[r][c] <= EPROD_W'(coef_of(regs_ff[r], c)) * EPROD_W'(pt[c]);
            end
         end
      end
   end

   // Stage 2: eye coordinates, the translation column scaled to the point's Q.8.
   logic signed [EACC_W-1:0] eacc [4];
   logic signed [EYE_W-1:0]  eye_ff [4];
   logic                     s2_vld_ff;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         eacc[r] = EACC_W'(eprod_ff[r][0]) + EACC_W'(eprod_ff[r][1])
                 + EACC_W'(eprod_ff[r][2])
                 + (EACC_W'(coef_of(regs_ff[r], 3)) <<< PT_FRAC);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 4; r++) begin
            eye_ff[r] <= EYE_W'(rnd_shift(64'(eacc[r]), COEF_FRAC_BITS));
         end
      end
   end

   // Stage 3: projection products; eye z is kept for clip w.
   logic signed [CPROD_W-1:0] cprod_ff [3][4];
   logic signed [EYE_W-1:0]   ez_ff;
   logic                      s3_vld_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
               cprod_ff[r][c] <= CPROD_W'(coef_of(regs_ff[4 + r], c)) * CPROD_W'(eye_ff[c]);
            end
         end
         ez_ff <= eye_ff[2];
      end
   end

   // Stage 4: clip coordinates and clip w, which is minus eye z.
   logic signed [CACC_W-1:0] cacc [3];
   logic signed [CLIP_W-1:0] clip_ff [3];
   logic signed [W_W-1:0]    w_ff;
   logic                     s4_vld_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         cacc[r] = CACC_W'(cprod_ff[r][0]) + CACC_W'(cprod_ff[r][1])
                 + CACC_W'(cprod_ff[r][2]) + CACC_W'(cprod_ff[r][3]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            clip_ff[r] <= CLIP_W'(rnd_shift(64'(cacc[r]), COEF_FRAC_BITS));
         end
         w_ff <= W_W'(0) - W_W'(ez_ff);
      end
   end

   // Stage 5: magnitudes, the out-of-range test and the divider operands.
   // The rounded quotient is (2|c|*65536 + |w|) / (2|w|).
   logic [CLIP_W-1:0] uc [3];
   logic [W_W-1:0]    uw;
   logic [CMP_W-1:0]  wlim;
   logic [DIV_RW-1:0] num_ff [3];
   logic [DIV_RW-1:0] den_ff;
   side_type          side_in;

   always_comb begin
      uw      = w_ff[W_W-1] ? (W_W'(0) - W_W'(w_ff)) : W_W'(w_ff);
      wlim    = CMP_W'(uw) << NDC_SH;
      side_in.wzero = (w_ff == '0);
      for (int r = 0; r < 3; r++) begin
         uc[r] = clip_ff[r][CLIP_W-1] ? (CLIP_W'(0) - CLIP_W'(clip_ff[r])) : CLIP_W'(clip_ff[r]);
         side_in.lim[r] = (CMP_W'(uc[r]) >= wlim);
         side_in.neg[r] = clip_ff[r][CLIP_W-1] ^ w_ff[W_W-1];
      end
   end

   // Sidebands and valid bits that travel beside the divider stages; entry 0 sits
   // beside the divider operands.
   side_type side_ff [0:DIV_BITS];
   logic     dvld_ff [0:DIV_BITS];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            // A saturated lane feeds a zero numerator; its quotient is not used.
            num_ff[r] <= side_in.lim[r] ? '0
                       : ((DIV_RW'(uc[r]) << ONE_SH) + DIV_RW'(uw));
         end
         den_ff     <= DIV_RW'(uw) << 1;
         side_ff[0] <= side_in;
         for (int k = 0; k < DIV_BITS; k++) begin
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   logic [DIV_BITS-1:0] quo [3];

   for (genvar r = 0; r < 3; r++) begin : g_div
      vtw_divider u_div (
         .clock   (clock),
         .en      (en),
         .num_in  (num_ff[r]),
         .den_in  (den_ff),
         .quo_out (quo[r])
      );
   end

   // Post stage 1: signed normalised coordinates, viewport products and depth.
   logic signed [NDC_W-1:0]   ndc [3];
   logic signed [NDC_W:0]     one [3];
   logic [DIV_BITS-1:0]       qsel [3];
   logic signed [63:0]        dr;
   logic signed [NDC_W+LANE_W:0] sprod_ff [2];
   logic [DEPTH_W-1:0]        dep_ff;
   logic                      dep_clamp_ff;
   logic                      p1_wzero_ff;
   logic                      p1_vld_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         qsel[r] = side_ff[DIV_BITS].lim[r] ? NDC_LIMIT : quo[r];
         ndc[r]  = side_ff[DIV_BITS].neg[r] ? (NDC_W'(0) - NDC_W'(qsel[r])) : NDC_W'(qsel[r]);
         one[r]  = (NDC_W + 1)'(ndc[r]) + ONE_Q16;
      end
      dr = rnd_shift(64'(one[2]), 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 2; r++) begin
            sprod_ff[r] <= (NDC_W + LANE_W + 1)'(one[r])
                         * (NDC_W + LANE_W + 1)'(signed'(regs_ff[REG_VIEWPORT[REG_IDX_W-1:0]]
                                                          [LANE_W*(r+2) +: LANE_W]));
         end
         // The far plane lands on 1.0, which saturates like any other overflow.
         if (dr < 0) begin
            dep_ff       <= '0;
            dep_clamp_ff <= 1'b1;
         end else if (dr > DEP_MAX) begin
            dep_ff       <= '1;
            dep_clamp_ff <= 1'b1;
         end else begin
            dep_ff       <= DEPTH_W'(dr);
            dep_clamp_ff <= 1'b0;
         end
         p1_wzero_ff <= side_ff[DIV_BITS].wzero;
      end
   end

   // Post stage 2: rounding, origin offset and saturation into the output register.
   logic signed [63:0]     sv [2];
   logic signed [PT_W-1:0] scr [2];
   logic [1:0]             scr_clamp;

   always_comb begin
      for (int r = 0; r < 2; r++) begin
         sv[r] = rnd_shift(64'(sprod_ff[r]), NDC_SH)
               + (64'(signed'(regs_ff[REG_VIEWPORT[REG_IDX_W-1:0]][LANE_W*r +: LANE_W]))
                  <<< PT_FRAC);
         if (sv[r] < SCR_MIN) begin
            scr[r]       = PT_W'(SCR_MIN);
            scr_clamp[r] = 1'b1;
         end else if (sv[r] > SCR_MAX) begin
            scr[r]       = PT_W'(SCR_MAX);
            scr_clamp[r] = 1'b1;
         end else begin
            scr[r]       = PT_W'(sv[r]);
            scr_clamp[r] = 1'b0;
         end
      end
   end

   logic signed [PT_W-1:0] out_x_ff;
   logic signed [PT_W-1:0] out_y_ff;
   logic [DEPTH_W-1:0]     out_dep_ff;
   logic                   out_res_ff;
   logic                   out_clamp_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         // Zero clip w has no projection: every field reads as zero.
         if (p1_wzero_ff) begin
            out_x_ff     <= '0;
            out_y_ff     <= '0;
            out_dep_ff   <= '0;
            out_res_ff   <= 1'b0;
            out_clamp_ff <= 1'b0;
         end else begin
            out_x_ff     <= scr[0];
            out_y_ff     <= scr[1];
            out_dep_ff   <= dep_ff;
            out_res_ff   <= 1'b1;
            out_clamp_ff <= |scr_clamp || dep_clamp_ff;
         end
      end
   end

   // Valid bits, cleared by reset and shifted with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         for (int k = 0; k <= DIV_BITS; k++) begin
            dvld_ff[k] <= 1'b0;
         end
         p1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff  <= req_valid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         dvld_ff[0] <= s4_vld_ff;
         for (int k = 0; k < DIV_BITS; k++) begin
            dvld_ff[k+1] <= dvld_ff[k];
         end
         p1_vld_ff  <= dvld_ff[DIV_BITS];
         out_vld_ff <= p1_vld_ff;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_screen_x  = out_x_ff;
   assign rsp_screen_y  = out_y_ff;
   assign rsp_depth     = out_dep_ff;
   assign rsp_valid_res = out_res_ff;
   assign rsp_clamped   = out_clamp_ff;

endmodule

[tb/tb_vertex_to_window_projection_top.sv]
// Self-checking testbench of the vertex-to-window projection pipeline.
module tb_vertex_to_window_projection_top;
   import vtw_pkg::*;

   // Clock, reset and the cycle limit that ends a hung run.
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [23:0] req_point_x = '0;
   logic signed [23:0] req_point_y = '0;
   logic signed [23:0] req_point_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [23:0] rsp_screen_x;
   logic signed [23:0] rsp_screen_y;
   logic [15:0] rsp_depth;
   logic rsp_valid_res;
   logic rsp_clamped;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0] csr_data = '0;

   vertex_to_window_projection_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_point_x(req_point_x), .req_point_y(req_point_y), .req_point_z(req_point_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_screen_x(rsp_screen_x), .rsp_screen_y(rsp_screen_y), .rsp_depth(rsp_depth),
      .rsp_valid_res(rsp_valid_res), .rsp_clamped(rsp_clamped),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // One window result as the block presents it.
   typedef struct {
      logic signed [23:0] sx;
      logic signed [23:0] sy;
      logic [15:0] dep;
      logic ok;
      logic clamp;
   } window_pt;

   // One row of the directed table; has_known marks a result typed in by hand.
   typedef struct {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
      bit has_known;
      window_pt known;
   } point_row;

   // Local copy of the register file, kept in step with every csr transfer.
   logic [REG_W-1:0] shadow_regs [NUM_REGS];

   window_pt pending_windows[$];
   int mismatch_count = 0;
   int cycle_count = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch on %s: got %0d, want %0d", what, got, want);
      mismatch_count++;
   endtask

   // Rounds to nearest with ties away from zero.
   function automatic longint div_nearest(input longint n, input longint d);
      longint un, ud, q;
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      q = (2 * un + ud) / (2 * ud);
      return ((n < 0) != (d < 0)) ? -q : q;
   endfunction

   function automatic longint lane_coef(input int r, input int c);
      logic signed [15:0] lane;
      lane = shadow_regs[r][16*c +: 16];
      return longint'(lane);
   endfunction

   function automatic longint clip_to_ndc(input longint cv, input longint w);
      longint mc, mw;
      mc = (cv < 0) ? -cv : cv;
      mw = (w < 0) ? -w : w;
      if (mc >= mw * 512)
         return ((cv < 0) != (w < 0)) ? -(longint'(1) << 25) : (longint'(1) << 25);
      return div_nearest(cv * 65536, w);
   endfunction

   // Predicts the window coordinates of one scene point from the shadow registers.
   function automatic window_pt project_point(input logic signed [23:0] px,
                                              input logic signed [23:0] py,
                                              input logic signed [23:0] pz);
      longint pt[3];
      longint eye[4];
      longint clip[3];
      longint ndc[3];
      longint acc, w, org, sz, v, d;
      window_pt res;
      pt[0] = px;
      pt[1] = py;
      pt[2] = pz;
      res = '{sx: '0, sy: '0, dep: '0, ok: 1'b0, clamp: 1'b0};
      for (int r = 0; r < 4; r++) begin
         acc = lane_coef(r, 3) * 256;
         for (int c = 0; c < 3; c++) acc += lane_coef(r, c) * pt[c];
         eye[r] = div_nearest(acc, 1 << COEF_FRAC_BITS);
      end
      for (int r = 0; r < 3; r++) begin
         acc = 0;
         for (int c = 0; c < 4; c++) acc += lane_coef(4 + r, c) * eye[c];
         clip[r] = div_nearest(acc, 1 << COEF_FRAC_BITS);
      end
      w = -eye[2];
      if (w == 0) return res;
      res.ok = 1'b1;
      for (int r = 0; r < 3; r++) ndc[r] = clip_to_ndc(clip[r], w);
      for (int r = 0; r < 2; r++) begin
         org = longint'($signed(shadow_regs[REG_VIEWPORT][16*r +: 16]));
         sz = longint'($signed(shadow_regs[REG_VIEWPORT][16*(r+2) +: 16]));
         v = div_nearest((ndc[r] + 65536) * sz, 512) + org * 256;
         if (v < -8388608) begin
            v = -8388608;
            res.clamp = 1'b1;
         end else if (v > 8388607) begin
            v = 8388607;
            res.clamp = 1'b1;
         end
         if (r == 0) res.sx = v[23:0];
         else res.sy = v[23:0];
      end
      d = div_nearest(ndc[2] + 65536, 2);
      if (d < 0) begin
         d = 0;
         res.clamp = 1'b1;
      end else if (d > 65535) begin
         d = 65535;
         res.clamp = 1'b1;
      end
      res.dep = d[15:0];
      return res;
   endfunction

   task automatic idle_cycles(input int n);
      repeat (n) @(posedge clock);
   endtask

   // Writes one register while the pipeline is idle and mirrors it locally.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx < NUM_REGS) shadow_regs[idx] = val;
      @(posedge clock);
   endtask

   // Sends one point; the expectation is queued at the accepting edge. Valid is
   // only dropped when a gap is drawn, so points can follow back to back.
   task automatic send_point(input logic signed [23:0] x, input logic signed [23:0] y,
                             input logic signed [23:0] z, input bit has_known,
                             input window_pt known);
      int gap;
      gap = $urandom_range(0, 4) * ($urandom_range(0, 3) != 0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         idle_cycles(gap);
      end
      req_valid <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      do @(posedge clock); while (!req_ready);
      pending_windows.push_back(has_known ? known : project_point(x, y, z));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_windows.size() != 0) @(posedge clock);
      idle_cycles(DRAIN_CYCLES);
   endtask

   function automatic logic [15:0] rand_coef();
      case ($urandom_range(0, 5))
         0: return 16'h0100;
         1: return 16'hFF00;
         2: return 16'h7FFF;
         3: return 16'h8000;
         default: return 16'($signed($urandom_range(0, 1024)) - 512);
      endcase
   endfunction

   function automatic logic signed [23:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return 24'($urandom);
         default: return 24'($signed($urandom_range(0, 8192)) - 4096);
      endcase
   endfunction

   // Results are taken at the rising edge, with a random stall drawn per item.
   initial begin : result_side
      int stall;
      window_pt exp_win;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 4) * ($urandom_range(0, 3) != 0);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            idle_cycles(stall);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_windows.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            exp_win = pending_windows.pop_front();
            if (rsp_valid_res !== exp_win.ok)
               report_mismatch("valid_res", rsp_valid_res, exp_win.ok);
            if (rsp_screen_x !== exp_win.sx)
               report_mismatch("screen_x", rsp_screen_x, exp_win.sx);
            if (rsp_screen_y !== exp_win.sy)
               report_mismatch("screen_y", rsp_screen_y, exp_win.sy);
            if (rsp_depth !== exp_win.dep)
               report_mismatch("depth", rsp_depth, exp_win.dep);
            if (rsp_clamped !== exp_win.clamp)
               report_mismatch("clamped", rsp_clamped, exp_win.clamp);
         end
      end
   end

   // The cycle counter guards against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[vertex_to_window_projection_top] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      point_row rows[$];
      window_pt zero_win;
      window_pt near_win;
      logic [15:0] lanes[4];
      zero_win = '{sx: '0, sy: '0, dep: '0, ok: 1'b0, clamp: 1'b0};
      // With identity matrices clip z equals minus clip w, so ndc z is -1 and the
      // depth lands exactly on zero without saturating.
      near_win = '{sx: '0, sy: '0, dep: 16'h0000, ok: 1'b1, clamp: 1'b0};
      shadow_regs[0] = 64'd256;
      shadow_regs[1] = 64'd256 << 16;
      shadow_regs[2] = 64'd256 << 32;
      shadow_regs[3] = 64'd256 << 48;
      shadow_regs[4] = 64'd256;
      shadow_regs[5] = 64'd256 << 16;
      shadow_regs[6] = 64'd256 << 32;
      shadow_regs[7] = 64'd0;
      idle_cycles(6);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table under the reset registers: a point on the eye plane has
      // zero clip w, and a point at z = -1.0 maps to depth zero.
      rows.push_back('{0, 0, 0, 1'b1, zero_win});
      rows.push_back('{24'sh7FFFFF, 24'sh800000, 0, 1'b1, zero_win});
      rows.push_back('{0, 0, -24'sd256, 1'b1, near_win});
      rows.push_back('{0, 0, 24'sh7FFFFF, 1'b0, zero_win});
      rows.push_back('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 1'b0, zero_win});
      rows.push_back('{24'sh800000, 24'sh800000, 24'sh7FFFFF, 1'b0, zero_win});
      rows.push_back('{24'sd512, -24'sd256, -24'sd1, 1'b0, zero_win});
      rows.push_back('{-24'sd1, 24'sd1, 24'sd1, 1'b0, zero_win});
      foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].has_known,
                                   rows[i].known);
      wait_drained();

      // A large viewport drives screen x and y into saturation.
      write_register(REG_VIEWPORT, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
      rows.delete();
      rows.push_back('{24'sd256, 24'sd256, -24'sd256, 1'b0, zero_win});
      rows.push_back('{24'sh7FFFFF, 24'sh800000, -24'sd1, 1'b0, zero_win});
      rows.push_back('{-24'sd512, 24'sd512, -24'sd1024, 1'b0, zero_win});
      write_register(REG_PJ_ROW2, {16'h0000, 16'h8000, 16'h0000, 16'h0000});
      foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, 1'b0, zero_win);
      wait_drained();
      // An unknown index must be ignored by the block.
      write_register(4'd8 + 4'($urandom_range(0, 7)), 64'hFFFF_FFFF_FFFF_FFFF);

      // Random phases: fresh registers, then a burst of points.
      for (int phase = 0; phase < 14; phase++) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            if (phase == 0 || $urandom_range(0, 2) == 0) begin
               foreach (lanes[k]) lanes[k] = rand_coef();
               if (r == REG_VIEWPORT)
                  foreach (lanes[k])
                     lanes[k] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                : 16'($urandom_range(0, 1024));
               if (phase == 13) lanes = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
               write_register(CSR_IDX_W'(r), {lanes[3], lanes[2], lanes[1], lanes[0]});
            end
         end
         for (int n = 0; n < 75; n++) begin
            send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, zero_win);
            // Once, hold the sender back until everything has come out.
            if (phase == 5 && n == 30) begin
               req_valid <= 1'b0;
               while (pending_windows.size() != 0) @(posedge clock);
            end
         end
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("[vertex_to_window_projection_top] OK");
      end else begin
         $display("[vertex_to_window_projection_top] ERROR");
      end
      $finish;
   end

endmodule
